// ----- design/rfsd_pkg.sv -----
// Package for the radar frame sync decoder: widths, header pattern, reset values,
// the result types and the sign-magnitude decode.
// No dependencies; every other design file imports it.
package rfsd_pkg;

   // Default frame geometry
   localparam int FRAME_BYTES_DEF  = 30;
   localparam int HEADER_BYTES_DEF = 4;

   // Fixed field widths and target layout
   localparam int BYTE_W     = 8;
   localparam int WORD_W     = 16;
   localparam int TARGET_LEN = 8;
   localparam int TGT_IDX_W  = $clog2(TARGET_LEN);
   localparam int DEC_W      = 8;

   localparam logic [DEC_W-1:0] DECIMATION_RESET = 8'd5;

   // Header bytes, matched by position
   localparam logic [BYTE_W-1:0] SYNC_PATTERN [4] = '{8'hAA, 8'hFF, 8'h03, 8'h00};

   localparam logic [WORD_W-1:0] SM_MAG_MASK = 16'h7fff;

   // One decoded target
   typedef struct packed {
      logic signed [WORD_W-1:0] x_mm;
      logic signed [WORD_W-1:0] y_mm;
      logic signed [WORD_W-1:0] speed_val;
      logic        [WORD_W-1:0] resolution_raw;
   } result_type;

   // Frame tracker to top level: result strobe and payload
   typedef struct packed {
      logic       emit;
      result_type res;
   } track_type;

   // Sign bit set means positive magnitude; clear means negate the whole word
   function automatic logic signed [WORD_W-1:0] sm_decode(input logic [WORD_W-1:0] w);
      logic [WORD_W-1:0] r;
      if (w[WORD_W-1]) begin
         r = w & SM_MAG_MASK;
      end else begin
         r = ~w + 16'd1;
      end
      return $signed(r);
   endfunction

endpackage

// ----- design/rfsd_channels.sv -----
// Channel interfaces for the radar frame sync decoder: byte input, decoded
// result and decimation register write. Depends on rfsd_pkg.
interface rfsd_req_if;
   import rfsd_pkg::*;
   logic              valid;
   logic              ready;
   logic [BYTE_W-1:0] rx_byte;
   modport source (output valid, output rx_byte, input ready);
   modport sink   (input valid, input rx_byte, output ready);
endinterface

interface rfsd_rsp_if;
   import rfsd_pkg::*;
   logic                     valid;
   logic                     ready;
   logic signed [WORD_W-1:0] x_mm;
   logic signed [WORD_W-1:0] y_mm;
   logic signed [WORD_W-1:0] speed_val;
   logic        [WORD_W-1:0] resolution_raw;
   modport source (output valid, output x_mm, output y_mm, output speed_val,
                   output resolution_raw, input ready);
   modport sink   (input valid, input x_mm, input y_mm, input speed_val,
                   input resolution_raw, output ready);
endinterface

interface rfsd_csr_if;
   import rfsd_pkg::*;
   logic             valid;
   logic             ready;
   logic [DEC_W-1:0] decimation;
   modport source (output valid, output decimation, input ready);
   modport sink   (input valid, input decimation, output ready);
endinterface

// ----- design/rfsd_frame_track.sv -----
// Frame tracker: header match by position, frame byte count, target one
// capture, decimation phase and result decode. Depends on rfsd_pkg.
module rfsd_frame_track #(
   parameter int FRAME_BYTES  = rfsd_pkg::FRAME_BYTES_DEF,
   parameter int HEADER_BYTES = rfsd_pkg::HEADER_BYTES_DEF
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         step,
   input  logic [rfsd_pkg::BYTE_W-1:0]  rx_byte,
   input  logic [rfsd_pkg::DEC_W-1:0]   decimation,
   output rfsd_pkg::track_type          track
);
   import rfsd_pkg::*;

   localparam int POS_W = $clog2(FRAME_BYTES);
   localparam logic [POS_W-1:0] HDR_POS  = POS_W'(HEADER_BYTES);
   localparam logic [POS_W-1:0] CAP_END  = POS_W'(HEADER_BYTES + TARGET_LEN);
   localparam logic [POS_W-1:0] LAST_POS = POS_W'(FRAME_BYTES - 1);

   logic [POS_W-1:0]  pos_ff, pos_in;
   logic [DEC_W-1:0]  phase_ff, phase_in;
   logic [BYTE_W-1:0] target_ff [TARGET_LEN];
   logic [BYTE_W-1:0] tgt_view [TARGET_LEN];
   logic              cap_en;
   logic [TGT_IDX_W-1:0] cap_idx;
   logic [DEC_W-1:0]  dec_eff;
   logic              emit;

   // Treat a zero decimation as one
   assign dec_eff = (decimation == '0) ? DEC_W'(1) : decimation;

   // Next position and phase for the byte in hand
   always_comb begin
      pos_in   = pos_ff;
      phase_in = phase_ff;
      emit     = 1'b0;
      if (step) begin
         priority if (pos_ff < HDR_POS) begin
            if (rx_byte != SYNC_PATTERN[pos_ff[1:0]]) begin
               pos_in = '0;
            end else begin
               pos_in = pos_ff + POS_W'(1);
            end
         end else if (pos_ff == LAST_POS) begin
            pos_in = '0;
            if (({1'b0, phase_ff} + 9'd1) >= {1'b0, dec_eff}) begin
               phase_in = '0;
               emit     = 1'b1;
            end else begin
               phase_in = phase_ff + DEC_W'(1);
            end
         end else begin
            pos_in = pos_ff + POS_W'(1);
         end
      end
   end

   // Target one sits directly after the header
   assign cap_en  = step && (pos_ff >= HDR_POS) && (pos_ff < CAP_END);
   assign cap_idx = TGT_IDX_W'(pos_ff - HDR_POS);

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff   <= '0;
         phase_ff <= '0;
      end else begin
         pos_ff   <= pos_in;
         phase_ff <= phase_in;
      end
   end

   // Capture target bytes; no reset needed
   always_ff @(posedge clock) begin
      if (cap_en) begin
         target_ff[cap_idx] <= rx_byte;
      end
   end

   // Forward the byte being captured, for a frame that ends on target one's last byte
   always_comb begin
      for (int i = 0; i < TARGET_LEN; i++) begin
         tgt_view[i] = (cap_en && (cap_idx == TGT_IDX_W'(i))) ? rx_byte : target_ff[i];
      end
   end

   // Decode little-endian words of target one
   always_comb begin
      track.emit               = emit;
      track.res.x_mm           = sm_decode({tgt_view[1], tgt_view[0]});
      track.res.y_mm           = sm_decode({tgt_view[3], tgt_view[2]});
      track.res.speed_val      = sm_decode({tgt_view[5], tgt_view[4]});
      track.res.resolution_raw = {tgt_view[7], tgt_view[6]};
   end

endmodule

// ----- design/radar_frame_sync_decoder.sv -----
// Top level of the radar frame sync decoder: input byte register, frame
// tracker, result register and decimation register.
// Depends on rfsd_pkg, rfsd_channels and rfsd_frame_track.
//
//   channel   modport  payload                                     role
//   req_bus   sink     rx_byte[7:0]                                received link bytes
//   rsp_bus   source   x_mm, y_mm, speed_val (s16), resolution_raw decoded target one
//   csr_bus   sink     decimation[7:0]                             result every N frames
//
// A byte is taken every cycle unless a result not taken stalls it; it passes the input
// register and is decoded by the tracker into the result register.
// The rate is set by the single tracker step between input and result register.
// Reset (synchronous) clears position, phase, stage valids and sets decimation to 5.
// A result not taken stalls the input register; bytes keep flowing otherwise.
module radar_frame_sync_decoder #(
   parameter int FRAME_BYTES  = rfsd_pkg::FRAME_BYTES_DEF,
   parameter int HEADER_BYTES = rfsd_pkg::HEADER_BYTES_DEF
) (
   input  logic        clock,
   input  logic        reset,
   rfsd_req_if.sink    req_bus,
   rfsd_rsp_if.source  rsp_bus,
   rfsd_csr_if.sink    csr_bus
);
   import rfsd_pkg::*;

   logic              in_valid_ff, in_valid_in;
   logic [BYTE_W-1:0] in_byte_ff;
   logic              rsp_valid_ff, rsp_valid_in;
   result_type        rsp_data_ff;
   logic [DEC_W-1:0]  decimation_ff;
   logic              req_take;
   logic              advance;
   logic              step;
   track_type         track;

   // Stage moves when the result register is free or being emptied
   assign advance         = !rsp_valid_ff || rsp_bus.ready;
   assign step            = in_valid_ff && advance;
   assign req_bus.ready   = !in_valid_ff || advance;
   assign req_take        = req_bus.valid && req_bus.ready;
   assign csr_bus.ready   = 1'b1;

   // Hold or refill the input register
   always_comb begin
      priority if (req_take) begin
         in_valid_in = 1'b1;
      end else if (step) begin
         in_valid_in = 1'b0;
      end else begin
         in_valid_in = in_valid_ff;
      end
   end

   // Load the result register on emit, drop it once taken
   always_comb begin
      priority if (step && track.emit) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_bus.ready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff   <= 1'b0;
         rsp_valid_ff  <= 1'b0;
         decimation_ff <= DECIMATION_RESET;
      end else begin
         in_valid_ff  <= in_valid_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_bus.valid) begin
            decimation_ff <= csr_bus.decimation;
         end
      end
   end

   // Payload registers
   always_ff @(posedge clock) begin
      if (req_take) begin
         in_byte_ff <= req_bus.rx_byte;
      end
      if (step && track.emit) begin
         rsp_data_ff <= track.res;
      end
   end

   rfsd_frame_track #(
      .FRAME_BYTES  (FRAME_BYTES),
      .HEADER_BYTES (HEADER_BYTES)
   ) u_track (
      .clock      (clock),
      .reset      (reset),
      .step       (step),
      .rx_byte    (in_byte_ff),
      .decimation (decimation_ff),
      .track      (track)
   );

   assign rsp_bus.valid          = rsp_valid_ff;
   assign rsp_bus.x_mm           = rsp_data_ff.x_mm;
   assign rsp_bus.y_mm           = rsp_data_ff.y_mm;
   assign rsp_bus.speed_val      = rsp_data_ff.speed_val;
   assign rsp_bus.resolution_raw = rsp_data_ff.resolution_raw;

endmodule

// ----- test/testbench.sv -----
`timescale 1ns / 100ps
// Self-checking testbench for radar_frame_sync_decoder: drives link bytes,
// predicts the decoded target of each decimated frame and checks every result.
// Depends on rfsd_pkg, the rfsd channel interfaces and the design top level.
module testbench;
   import rfsd_pkg::*;

   localparam int          HDR_LEN      = 4;
   localparam int          FRAME_LEN    = 30;
   localparam int          TGT_LEN      = 8;
   localparam logic [7:0]  SYNC [4]     = '{8'hAA, 8'hFF, 8'h03, 8'h00};
   localparam int          DRAIN_CYC    = 6;
   localparam int          RANDOM_ITEMS = 1300;
   localparam int          MAX_WAIT     = 14;
   localparam longint      TIMEOUT_NS   = 5_000_000;

   logic clock = 1'b0;
   logic reset = 1'b1;

   rfsd_req_if req_bus();
   rfsd_rsp_if rsp_bus();
   rfsd_csr_if csr_bus();

   radar_frame_sync_decoder i_dut (
      .clock   (clock),
      .reset   (reset),
      .req_bus (req_bus),
      .rsp_bus (rsp_bus),
      .csr_bus (csr_bus)
   );

   // Frame tracker shadow state
   int         frame_pos;
   int         frames_done;
   logic [7:0] decim_shadow;
   logic [7:0] tgt_bytes [TGT_LEN];
   result_type target_due [$];

   int mismatches;
   int bytes_sent;
   bit req_idle;
   bit rsp_idle;

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   initial begin
      #(TIMEOUT_NS);
      $display("Verification failed");
      $finish;
   end

   function automatic int draw_wait(bit enable);
      return enable ? $urandom_range(0, MAX_WAIT) : 0;
   endfunction

   // Sign bit set: positive magnitude; clear: two's complement of the word
   function automatic logic signed [15:0] unfold_sm(logic [15:0] w);
      if (w[15]) begin
         return {1'b0, w[14:0]};
      end
      return 16'd0 - w;
   endfunction

   function automatic logic [15:0] tgt_word(int lo);
      return {tgt_bytes[lo + 1], tgt_bytes[lo]};
   endfunction

   // Advance the shadow tracker by one byte; queue a target at a decimated frame end
   function automatic void track_frame_byte(logic [7:0] b);
      int         eff;
      result_type tgt;
      if (frame_pos < HDR_LEN) begin
         frame_pos = (b == SYNC[frame_pos]) ? frame_pos + 1 : 0;
         return;
      end
      if (frame_pos < HDR_LEN + TGT_LEN) begin
         tgt_bytes[frame_pos - HDR_LEN] = b;
      end
      frame_pos++;
      if (frame_pos < FRAME_LEN) begin
         return;
      end
      frame_pos = 0;
      eff = (decim_shadow == 8'd0) ? 1 : int'(decim_shadow);
      if (frames_done + 1 >= eff) begin
         frames_done = 0;
      end else begin
         frames_done++;
         return;
      end
      tgt.x_mm           = unfold_sm(tgt_word(0));
      tgt.y_mm           = unfold_sm(tgt_word(2));
      tgt.speed_val      = unfold_sm(tgt_word(4));
      tgt.resolution_raw = tgt_word(6);
      target_due.push_back(tgt);
   endfunction

   // Send one byte, after a random gap when req_idle is set; valid stays high across back-to-back bytes
   task automatic send_byte(input logic [7:0] b);
      int gap;
      gap = draw_wait(req_idle);
      @(negedge clock);
      if (gap > 0) begin
         req_bus.valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_bus.valid   <= 1'b1;
      req_bus.rx_byte <= b;
      do @(posedge clock); while (!req_bus.ready);
      bytes_sent++;
      track_frame_byte(b);
   endtask

   // Drop valid, wait for every queued target, then let the pipeline empty
   task automatic settle();
      @(negedge clock);
      req_bus.valid <= 1'b0;
      while (target_due.size() != 0) @(posedge clock);
      repeat (DRAIN_CYC) @(negedge clock);
   endtask

   task automatic set_decimation(input logic [7:0] value);
      settle();
      @(negedge clock);
      csr_bus.valid      <= 1'b1;
      csr_bus.decimation <= value;
      do @(posedge clock); while (!csr_bus.ready);
      decim_shadow = value;
      @(negedge clock);
      csr_bus.valid <= 1'b0;
   endtask

   // Whole frame: header, target one little-endian, then an unchecked tail
   task automatic send_frame(input logic [15:0] xw, yw, sw, rw, input bit sync_tail);
      logic [63:0] body;
      body = {rw, sw, yw, xw};
      for (int i = 0; i < HDR_LEN; i++) send_byte(SYNC[i]);
      for (int i = 0; i < TGT_LEN; i++) send_byte(body[8*i +: 8]);
      for (int i = HDR_LEN + TGT_LEN; i < FRAME_LEN; i++) begin
         send_byte(sync_tail ? SYNC[i % HDR_LEN] : 8'($urandom_range(0, 255)));
      end
   endtask

   function automatic logic [15:0] pick_word();
      case ($urandom_range(0, 9))
         0: return 16'h0000;
         1: return 16'h8000;
         2: return 16'hFFFF;
         3: return 16'h7FFF;
         4: return 16'h0001;
         default: return 16'($urandom);
      endcase
   endfunction

   task automatic send_random_frame();
      send_frame(pick_word(), pick_word(), pick_word(), pick_word(),
                 $urandom_range(0, 15) == 0);
   endtask

   // Header that breaks after a random number of good bytes
   task automatic send_broken_header();
      int         good;
      logic [7:0] bad;
      good = $urandom_range(1, HDR_LEN - 1);
      for (int i = 0; i < good; i++) send_byte(SYNC[i]);
      do bad = 8'($urandom_range(0, 255)); while (bad == SYNC[good]);
      send_byte(bad);
   endtask

   // Mostly whole frames; the rest is noise, broken headers and cut frames
   task automatic send_packet();
      int kind;
      int len;
      kind = $urandom_range(0, 19);
      if (kind < 15) begin
         send_random_frame();
      end else if (kind < 17) begin
         len = $urandom_range(1, 12);
         repeat (len) send_byte(($urandom_range(0, 3) == 0) ? SYNC[0] :
                                8'($urandom_range(0, 255)));
      end else if (kind < 19) begin
         send_broken_header();
      end else begin
         len = $urandom_range(0, FRAME_LEN - HDR_LEN - 1);
         for (int i = 0; i < HDR_LEN; i++) send_byte(SYNC[i]);
         repeat (len) send_byte(8'($urandom_range(0, 255)));
      end
   endtask

   // Result sink: random stall before each transaction when rsp_idle is set
   initial begin
      int stall;
      rsp_bus.ready = 1'b0;
      forever begin
         stall = draw_wait(rsp_idle);
         if (stall > 0) begin
            rsp_bus.ready <= 1'b0;
            repeat (stall) @(negedge clock);
         end
         rsp_bus.ready <= 1'b1;
         do @(posedge clock); while (!(rsp_bus.valid && !reset));
         @(negedge clock);
      end
   end

   // Compare each result transaction with the oldest queued target
   always @(posedge clock) begin
      result_type want;
      if (!reset && rsp_bus.valid && rsp_bus.ready) begin
         if (target_due.size() == 0) begin
            $display("%0t: unexpected result x_mm %0d y_mm %0d speed_val %0d res %0d",
                     $time, rsp_bus.x_mm, rsp_bus.y_mm, rsp_bus.speed_val,
                     rsp_bus.resolution_raw);
            mismatches++;
         end else begin
            want = target_due.pop_front();
            if (rsp_bus.x_mm !== want.x_mm) begin
               $display("%0t: x_mm expected %0d, got %0d", $time, want.x_mm, rsp_bus.x_mm);
               mismatches++;
            end
            if (rsp_bus.y_mm !== want.y_mm) begin
               $display("%0t: y_mm expected %0d, got %0d", $time, want.y_mm, rsp_bus.y_mm);
               mismatches++;
            end
            if (rsp_bus.speed_val !== want.speed_val) begin
               $display("%0t: speed_val expected %0d, got %0d", $time, want.speed_val,
                        rsp_bus.speed_val);
               mismatches++;
            end
            if (rsp_bus.resolution_raw !== want.resolution_raw) begin
               $display("%0t: resolution_raw expected %0d, got %0d", $time,
                        want.resolution_raw, rsp_bus.resolution_raw);
               mismatches++;
            end
         end
      end
   end

   // Reset decimation of five: one target from five frames
   task automatic test_default_decimation();
      repeat (5) send_random_frame();
      settle();
   endtask

   // Decimation zero acts as one; decode at the word extremes
   task automatic test_word_extremes();
      set_decimation(8'd0);
      send_frame(16'h0000, 16'h8000, 16'hFFFF, 16'h0001, 1'b0);
      send_frame(16'h7FFF, 16'h0001, 16'h8000, 16'hFFFF, 1'b0);
      send_frame(16'h8001, 16'hFFFE, 16'h7FFE, 16'h0000, 1'b0);
      settle();
   endtask

   // Header mismatches after one and after three good bytes; failing byte is not a new start
   task automatic test_header_mismatch();
      set_decimation(8'd1);
      send_byte(8'hAA); send_byte(8'hFF); send_byte(8'h03); send_byte(8'hAA);
      send_random_frame();
      send_byte(8'hAA); send_byte(8'hAA); send_byte(8'hFF); send_byte(8'h03);
      send_byte(8'h00);
      send_byte(8'hAA); send_byte(8'hFF); send_byte(8'h03); send_byte(8'h01);
      send_random_frame();
      settle();
   endtask

   // Tail carrying the header pattern must not resync mid-frame
   task automatic test_unchecked_tail();
      send_frame(16'h8123, 16'h0456, 16'hC000, 16'h1234, 1'b1);
      send_frame(16'h4321, 16'h9876, 16'h0101, 16'hA5A5, 1'b1);
      settle();
   endtask

   // Top decimation, then lower it below the frame count already reached
   task automatic test_decimation_lowered();
      set_decimation(8'd255);
      repeat (3) send_random_frame();
      set_decimation(8'd2);
      repeat (3) send_random_frame();
      settle();
   endtask

   // Random phases with varied decimation and idling on either side
   task automatic test_random_traffic();
      int first_byte;
      int phase_start;
      int phase_len;
      first_byte = bytes_sent;
      while (bytes_sent - first_byte < RANDOM_ITEMS) begin
         case ($urandom_range(0, 7))
            0:       set_decimation(8'd1);
            1:       set_decimation(8'd0);
            2:       set_decimation(8'($urandom_range(5, 8)));
            default: set_decimation(8'($urandom_range(1, 4)));
         endcase
         req_idle    = $urandom_range(0, 3) != 0;
         rsp_idle    = $urandom_range(0, 3) != 0;
         phase_len   = $urandom_range(120, 360);
         phase_start = bytes_sent;
         while (bytes_sent - phase_start < phase_len) send_packet();
      end
      settle();
   endtask

   initial begin
      req_bus.valid      = 1'b0;
      req_bus.rx_byte    = 8'd0;
      csr_bus.valid      = 1'b0;
      csr_bus.decimation = 8'd0;
      frame_pos          = 0;
      frames_done        = 0;
      decim_shadow       = 8'd5;
      mismatches         = 0;
      bytes_sent         = 0;
      req_idle           = 1'b1;
      rsp_idle           = 1'b1;
      foreach (tgt_bytes[i]) tgt_bytes[i] = 8'd0;
      repeat (10) @(negedge clock);
      reset <= 1'b0;

      test_default_decimation();
      test_word_extremes();
      test_header_mismatch();
      test_unchecked_tail();
      test_decimation_lowered();
      test_random_traffic();

      if (mismatches == 0 && target_due.size() == 0) begin
         $display("Verification passed");
      end else begin
         $display("Verification failed");
      end
      $finish;
   end

endmodule

// ----- files.f -----
design/rfsd_pkg.sv
design/rfsd_channels.sv
design/rfsd_frame_track.sv
design/radar_frame_sync_decoder.sv
test/testbench.sv
